### rtl/quantized_phase_shifter_top_defines.svh
// Assertion macros shared by the checker of the quantized phase shifter.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef QUANTIZED_PHASE_SHIFTER_TOP_DEFINES_SVH
`define QUANTIZED_PHASE_SHIFTER_TOP_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define QPS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qps check failed");

// The consequent holds in the cycle after the antecedent.
`define QPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qps check failed");

`endif

### rtl/qps_pkg.sv
// Package of the quantized phase shifter: widths, constants, register indexes and states.
// Used by qps_hilbert_cell, qps_cordic and the top level; depends on nothing.
`default_nettype none
package qps_pkg;
	localparam int DW     = 16;
	localparam int ACC_W  = 50;
	localparam int XH_W   = 19;
	localparam int CS_W   = 17;
	localparam int CX_W   = 34;
	localparam int CZ_W   = 20;
	localparam int CSTAGES = 16;
	localparam int HCOEF  = 683565275;
	localparam logic signed [CX_W-1:0] CORDIC_K = 34'sd652032874;

	localparam logic [17:0] ATAN_TAB [CSTAGES] = '{
		18'd131072, 18'd77376, 18'd40884, 18'd20753, 18'd10417, 18'd5213,
		18'd2607, 18'd1304, 18'd652, 18'd326, 18'd163, 18'd81, 18'd41,
		18'd20, 18'd10, 18'd5
	};

	localparam logic [2:0] REG_SIGNAL_MODE  = 3'd0;
	localparam logic [2:0] REG_PHASE_SOURCE = 3'd1;
	localparam logic [2:0] REG_FIXED_PHASE  = 3'd2;
	localparam logic [2:0] REG_CONTROL_GAIN = 3'd3;
	localparam logic [2:0] REG_QUANT_BITS   = 3'd4;
	localparam logic [2:0] REG_PHASE_OFFSET = 3'd5;
	localparam logic [2:0] REG_GAIN         = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MULC,
		ST_ANGLE,
		ST_ROT,
		ST_MUL1,
		ST_MUL2,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

### rtl/qps_hilbert_cell.sv
// One cell of the Hilbert filter chain: a history sample and a transposed partial sum.
// Depends on qps_pkg.
`default_nettype none
module qps_hilbert_cell #(
	parameter int COEF = 0
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            en,
	input  wire logic signed [qps_pkg::DW-1:0]    x,
	input  wire logic signed [qps_pkg::DW-1:0]    d_in,
	output logic signed [qps_pkg::DW-1:0]         d_out,
	input  wire logic signed [qps_pkg::ACC_W-1:0] p_in,
	output logic signed [qps_pkg::ACC_W-1:0]      p_out
);
	logic signed [31:0] coef_w;
	logic signed [47:0] prod;
	logic signed [qps_pkg::DW-1:0] d_q;
	logic signed [qps_pkg::ACC_W-1:0] p_q;

	assign coef_w = 32'(COEF);
	assign prod = coef_w * x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= '0;
			p_q <= '0;
		end else if (en) begin
			d_q <= d_in;
			p_q <= p_in + qps_pkg::ACC_W'(prod);
		end
	end

	assign d_out = d_q;
	assign p_out = p_q;
endmodule
`default_nettype wire

### rtl/qps_cordic.sv
// Iterative CORDIC giving rounded Q2.15 cosine and sine of a binary angle, one stage a cycle.
// Depends on qps_pkg.
`default_nettype none
module qps_cordic (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [15:0]                   ang,
	output logic                               done,
	output logic signed [qps_pkg::CS_W-1:0]    cos_o,
	output logic signed [qps_pkg::CS_W-1:0]    sin_o
);
	logic signed [qps_pkg::CX_W-1:0] x_q, y_q, dx, dy;
	logic signed [qps_pkg::CZ_W-1:0] z_q, at;
	logic [1:0] quad_q;
	logic [3:0] cnt_q;
	logic busy_q, done_q;
	logic signed [18:0] xr, yr;
	logic signed [qps_pkg::CS_W-1:0] c, s;

	assign dx = y_q >>> cnt_q;
	assign dy = x_q >>> cnt_q;
	assign at = qps_pkg::CZ_W'(qps_pkg::ATAN_TAB[cnt_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= qps_pkg::CORDIC_K;
			y_q    <= '0;
			z_q    <= qps_pkg::CZ_W'({ang[13:0], 4'b0000});
			quad_q <= ang[15:14];
		end else if (busy_q) begin
			if (!z_q[qps_pkg::CZ_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	always_comb begin
		xr = 19'((x_q + 34'sd16384) >>> 15);
		yr = 19'((y_q + 34'sd16384) >>> 15);
		if (xr > 19'sd32768) c = 17'sd32768;
		else if (xr < -19'sd32768) c = -17'sd32768;
		else c = 17'(xr);
		if (yr > 19'sd32768) s = 17'sd32768;
		else if (yr < -19'sd32768) s = -17'sd32768;
		else s = 17'(yr);
		case (quad_q)
			2'd1: begin
				cos_o = -s;
				sin_o = c;
			end
			2'd2: begin
				cos_o = -c;
				sin_o = -s;
			end
			2'd3: begin
				cos_o = s;
				sin_o = -c;
			end
			default: begin
				cos_o = c;
				sin_o = s;
			end
		endcase
	end

	assign done = done_q;
endmodule
`default_nettype wire

### rtl/quantized_phase_shifter_top.sv
// Top level of the quantized phase shifter: registers, phase path, Hilbert chain, rotation.
// Depends on qps_pkg, qps_hilbert_cell and qps_cordic.
//
//  channel  | signals                        | contents
//  s        | s_tvalid s_tready s_tdata[47:0] | in_i, in_q, control
//  m        | m_tvalid m_tready m_tdata[31:0] | out_i, out_q
//  cfg      | cfg_valid cfg_ready cfg_index   | register write, data in cfg_data
//
// After a request is accepted, the control product is formed, the CORDIC is loaded and runs
// its 16 iterations, and the result is then latched, rotated, scaled and registered.
// A new request is taken only once the result has been registered.
// The result register holds a finished result while the next request is taken; a result
// still not taken then stalls the following one in the last stage.
// Reset clears the registers to their defaults and the filter history to zero.
`default_nettype none
module quantized_phase_shifter_top #(
	parameter int TAPS = 65
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // in_i [15:0], in_q [31:16], control [47:32]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // out_i [15:0], out_q [31:16]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);
	localparam int HLEN = TAPS | 1;
	localparam int HMID = (HLEN - 1) / 2;

	logic        signal_mode_q, phase_source_q;
	logic [15:0] fixed_phase_q, phase_offset_q, gain_q;
	logic signed [23:0] control_gain_q;
	logic [4:0]  quant_bits_q;

	qps_pkg::state_t state_q, state_d;

	logic signed [15:0] xi_q, xq_q, ctl_q;
	logic signed [39:0] prod_q;
	logic        accept;
	logic        cell_en;

	logic signed [qps_pkg::DW-1:0]    d_w [HLEN];
	logic signed [qps_pkg::ACC_W-1:0] p_w [HLEN];

	logic [15:0] d_ang, d_quant, ang;
	logic [3:0]  sh;
	logic [16:0] rsum;
	logic        cor_start, cor_done;
	logic signed [qps_pkg::CS_W-1:0] cos_w, sin_w, c_q, s_q;
	logic signed [qps_pkg::XH_W-1:0] xh_w, xh_q;
	logic signed [qps_pkg::ACC_W-1:0] acc_r;
	logic signed [qps_pkg::XH_W-1:0] a_w, b_w;
	logic signed [36:0] pi_s1, pq_s1;
	logic signed [54:0] gi_s2, gq_s2;
	logic [15:0] g_w;
	logic signed [15:0] ri_w, rq_w;
	logic signed [15:0] out_i_q, out_q_q;
	logic        m_valid_q;
	logic        out_load;

	function automatic logic signed [15:0] round_sat(input logic signed [54:0] v);
		logic signed [54:0] r;
		begin
			r = (v + 55'sd536870912) >>> 30;
			if (r > 55'sd32767) round_sat = 16'sh7FFF;
			else if (r < -55'sd32768) round_sat = 16'sh8000;
			else round_sat = 16'(r);
		end
	endfunction

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == qps_pkg::ST_IDLE);
	assign accept    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signal_mode_q  <= 1'b0;
			phase_source_q <= 1'b0;
			fixed_phase_q  <= '0;
			control_gain_q <= 24'sd16384;
			quant_bits_q   <= '0;
			phase_offset_q <= '0;
			gain_q         <= 16'd32768;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				qps_pkg::REG_SIGNAL_MODE:  signal_mode_q  <= cfg_data[0];
				qps_pkg::REG_PHASE_SOURCE: phase_source_q <= cfg_data[0];
				qps_pkg::REG_FIXED_PHASE:  fixed_phase_q  <= cfg_data[15:0];
				qps_pkg::REG_CONTROL_GAIN: control_gain_q <= cfg_data;
				qps_pkg::REG_QUANT_BITS:   quant_bits_q   <= cfg_data[4:0];
				qps_pkg::REG_PHASE_OFFSET: phase_offset_q <= cfg_data[15:0];
				qps_pkg::REG_GAIN:         gain_q         <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cell_en = accept && signal_mode_q;

	for (genvar k = 0; k < HLEN; k++) begin : g_cell
		localparam int M    = k - HMID;
		localparam int AM   = (M < 0) ? -M : M;
		localparam int HMAG = ((AM % 2) == 1) ? ((qps_pkg::HCOEF + AM / 2) / AM) : 0;
		localparam int COEF = (M < 0) ? -HMAG : HMAG;
		logic signed [qps_pkg::DW-1:0]    d_in_w;
		logic signed [qps_pkg::ACC_W-1:0] p_in_w;
		if (k == 0) begin : g_first
			assign d_in_w = s_tdata[15:0];
		end else begin : g_rest
			assign d_in_w = d_w[k-1];
		end
		if (k == HLEN - 1) begin : g_last
			assign p_in_w = '0;
		end else begin : g_inner
			assign p_in_w = p_w[k+1];
		end
		qps_hilbert_cell #(.COEF(COEF)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (cell_en),
			.x     (s_tdata[15:0]),
			.d_in  (d_in_w),
			.d_out (d_w[k]),
			.p_in  (p_in_w),
			.p_out (p_w[k])
		);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			xi_q  <= s_tdata[15:0];
			xq_q  <= s_tdata[31:16];
			ctl_q <= s_tdata[47:32];
		end
		if (state_q == qps_pkg::ST_MULC) prod_q <= control_gain_q * ctl_q;
	end

	always_comb begin
		d_ang = phase_source_q ? prod_q[30:15] : fixed_phase_q;
		sh    = 4'(5'd16 - quant_bits_q);
		rsum  = {1'b0, d_ang} + (17'd1 << (sh - 4'd1));
		if (quant_bits_q > 5'd0 && quant_bits_q < 5'd16)
			d_quant = rsum[15:0] & (16'hFFFF << sh);
		else
			d_quant = d_ang;
		ang = d_quant + phase_offset_q;
	end

	assign cor_start = (state_q == qps_pkg::ST_ANGLE);

	qps_cordic u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cor_start),
		.ang   (ang),
		.done  (cor_done),
		.cos_o (cos_w),
		.sin_o (sin_w)
	);

	assign acc_r = (p_w[0] + qps_pkg::ACC_W'(64'sd536870912)) >>> 30;
	assign xh_w  = qps_pkg::XH_W'(acc_r);
	assign a_w   = signal_mode_q ? qps_pkg::XH_W'(d_w[HMID]) : qps_pkg::XH_W'(xi_q);
	assign b_w   = signal_mode_q ? xh_q : qps_pkg::XH_W'(xq_q);
	assign g_w   = (gain_q > 16'd32768) ? 16'd32768 : gain_q;

	always_ff @(posedge clk) begin
		if (state_q == qps_pkg::ST_ROT && cor_done) begin
			c_q  <= cos_w;
			s_q  <= sin_w;
			xh_q <= xh_w;
		end
		if (state_q == qps_pkg::ST_MUL1) begin
			pi_s1 <= 37'(a_w * c_q) - 37'(b_w * s_q);
			pq_s1 <= 37'(a_w * s_q) + 37'(b_w * c_q);
		end
		if (state_q == qps_pkg::ST_MUL2) begin
			gi_s2 <= 55'(pi_s1) * 55'(signed'({1'b0, g_w}));
			gq_s2 <= 55'(pq_s1) * 55'(signed'({1'b0, g_w}));
		end
	end

	assign ri_w = round_sat(gi_s2);
	assign rq_w = signal_mode_q ? 16'sd0 : round_sat(gq_s2);
	assign out_load = (state_q == qps_pkg::ST_OUT) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_i_q <= ri_w;
			out_q_q <= rq_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= qps_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qps_pkg::ST_IDLE:  if (accept) state_d = qps_pkg::ST_MULC;
			qps_pkg::ST_MULC:  state_d = qps_pkg::ST_ANGLE;
			qps_pkg::ST_ANGLE: state_d = qps_pkg::ST_ROT;
			qps_pkg::ST_ROT:   if (cor_done) state_d = qps_pkg::ST_MUL1;
			qps_pkg::ST_MUL1:  state_d = qps_pkg::ST_MUL2;
			qps_pkg::ST_MUL2:  state_d = qps_pkg::ST_OUT;
			qps_pkg::ST_OUT:   if (out_load) state_d = qps_pkg::ST_IDLE;
			default:           state_d = qps_pkg::ST_IDLE;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {out_q_q, out_i_q};
endmodule
`default_nettype wire

### rtl/qps_checker.sv
// Port-level checker of the quantized phase shifter and its binding to the top level.
// Depends on quantized_phase_shifter_top_defines.svh.
`default_nettype none
`include "quantized_phase_shifter_top_defines.svh"
module qps_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);
	`QPS_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready)
	`QPS_ASSERT_NOW(a_result_at_ready, $rose(m_tvalid), s_tready)
	`QPS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

bind quantized_phase_shifter_top qps_checker u_qps_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
`default_nettype wire
